// ===== rtl/core/plyhdr_pkg.sv =====
package plyhdr_pkg;

  localparam int NKW = 9;

  // keyword slots, also the bit positions of the candidate mask
  localparam int W_PLY    = 0;
  localparam int W_V10    = 1;
  localparam int W_BLE    = 2;
  localparam int W_PROP   = 3;
  localparam int W_FLOAT  = 4;
  localparam int W_ELEM   = 5;
  localparam int W_VERTEX = 6;
  localparam int W_FORMAT = 7;
  localparam int W_END    = 8;

  // text right aligned: last character in the lowest byte
  localparam logic [255:0] KW_TEXT [NKW] = '{
    256'("ply"), 256'("1.0"), 256'({"binary_little", "_endian"}), 256'("property"),
    256'("float"), 256'("element"), 256'("vertex"), 256'("format"),
    256'({"end_", "header"})
  };
  localparam logic [4:0] KW_LEN [NKW] = '{
    5'd3, 5'd3, 5'd20, 5'd8, 5'd5, 5'd7, 5'd6, 5'd6, 5'd10
  };

  typedef enum logic [2:0] {
    K_NONE   = 3'd0,
    K_IGNORE = 3'd1,
    K_PROP   = 3'd2,
    K_FMT    = 3'd3,
    K_ELEM   = 3'd4,
    K_PLYOK  = 3'd5,
    K_END    = 3'd6
  } kind_t;

  localparam logic [3:0] E_NONE     = 4'd0;
  localparam logic [3:0] E_NO_PLY   = 4'd1;
  localparam logic [3:0] E_NOFLOAT  = 4'd2;
  localparam logic [3:0] E_NOT_BLE  = 4'd3;
  localparam logic [3:0] E_VERSION  = 4'd4;
  localparam logic [3:0] E_NOT_VERT = 4'd5;
  localparam logic [3:0] E_COUNT    = 4'd6;
  localparam logic [3:0] E_LINES    = 4'd7;
  localparam logic [3:0] E_NO_END   = 4'd8;

  localparam logic [11:0] MAX_LINES_RST = 12'd1000;

  typedef struct packed {
    logic [3:0] err;
    kind_t      kind;
    logic       inc_stride;
    logic       load_vc;
  } ev_t;

endpackage

// ===== rtl/core/ply_header_parser.sv =====
// Byte-stream parser for a binary little-endian PLY header with float
// vertex properties. One byte is taken per transfer and every byte yields
// exactly one registered result transfer; with out_tready held high a
// byte is accepted every cycle. Header lines are checked word by word with
// prefix matches; after the header end line, vertex_count * stride bytes are
// flagged as payload and later bytes are ignored. in_tlast marks the end of the
// first buffer, which must hold the whole header. Any error freezes the block and
// is repeated on every later result. cfg_wdata sets the header line limit.
module ply_header_parser #(
  parameter int COUNT_BITS  = 32,
  parameter int STRIDE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,   // max_header_lines
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // data_byte
  input  logic        in_tlast,    // chunk_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // payload_byte[7:0], header_done[8], payload_done[9], error_code[13:10],
  // vertex_count[45:14], stride_bytes[57:46], zero fill
  output logic [63:0] out_tdata,
  output logic        out_tuser    // payload_valid
);
  import plyhdr_pkg::*;

  localparam int TOT_BITS = COUNT_BITS + STRIDE_BITS;
  localparam logic [STRIDE_BITS-1:0] SMAX = '1;

  typedef enum logic [1:0] {PH_PLY, PH_HDR, PH_PAY, PH_STOP} phase_t;

  phase_t                  ph_r, ph_nxt;
  logic [11:0]             lc_r, lc_nxt;
  logic [11:0]             max_r;
  logic [2:0]              wi_r, wi_nxt;
  logic [4:0]              ciw_r, ciw_nxt;
  logic [NKW-1:0]          cand_r, cand_nxt;
  logic                    cok_r, cok_nxt;
  logic                    fl_r, fl_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [COUNT_BITS-1:0]   acc_r, acc_nxt;
  logic [STRIDE_BITS-1:0]  stride_r, stride_nxt;
  logic [COUNT_BITS-1:0]   vc_r, vc_nxt;
  logic [TOT_BITS-1:0]     total_r, seen_r, seen_nxt;
  logic [TOT_BITS-1:0]     prod;
  logic                    load_total;
  logic [3:0]              err_r, err_nxt;
  logic                    pv_nxt, stop;
  logic [COUNT_BITS+3:0]   tsum;
  logic [3:0]              digit;
  logic [4:0]              kidx;
  ev_t                     ev;
  logic [63:0]             odata_r;
  logic                    ouser_r, ovalid_r;

  logic in_fire;
  assign in_tready  = !ovalid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  assign prod = TOT_BITS'(vc_r) * TOT_BITS'(stride_r);

  function automatic logic hit(input logic [NKW-1:0] cand, input logic [4:0] ciw,
                               input int k);
    return cand[k] && (ciw >= KW_LEN[k]);
  endfunction

  function automatic ev_t eval_word(input logic [2:0] wi, input logic at_ply,
                                    input logic fl, input logic [NKW-1:0] cand,
                                    input logic [4:0] ciw, input kind_t kind,
                                    input logic cok);
    ev_t r;
    r = '{err: E_NONE, kind: kind, inc_stride: 1'b0, load_vc: 1'b0};
    if (wi == 3'd0) begin
      if (at_ply) begin
        if (!(fl && hit(cand, ciw, W_PLY))) r.err = E_NO_PLY;
        else r.kind = K_PLYOK;
      end else if (fl && hit(cand, ciw, W_END)) r.kind = K_END;
      else if (hit(cand, ciw, W_PROP))   r.kind = K_PROP;
      else if (hit(cand, ciw, W_FORMAT)) r.kind = K_FMT;
      else if (hit(cand, ciw, W_ELEM))   r.kind = K_ELEM;
      else r.kind = K_IGNORE;
    end else if (wi == 3'd1) begin
      if (kind == K_PROP) begin
        if (!hit(cand, ciw, W_FLOAT)) r.err = E_NOFLOAT;
        else r.inc_stride = 1'b1;
      end else if (kind == K_FMT) begin
        if (!hit(cand, ciw, W_BLE)) r.err = E_NOT_BLE;
      end else if (kind == K_ELEM) begin
        if (!hit(cand, ciw, W_VERTEX)) r.err = E_NOT_VERT;
      end
    end else if (wi == 3'd2) begin
      if (kind == K_FMT) begin
        if (!hit(cand, ciw, W_V10)) r.err = E_VERSION;
      end else if (kind == K_ELEM) begin
        if (!cok || ciw == 5'd0) r.err = E_COUNT;
        else r.load_vc = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] words_needed(input kind_t kind);
    case (kind) inside
      K_PROP:        return 3'd2;
      K_FMT, K_ELEM: return 3'd3;
      default:       return 3'd1;
    endcase
  endfunction

  always_comb begin
    ph_nxt = ph_r; lc_nxt = lc_r; wi_nxt = wi_r; ciw_nxt = ciw_r;
    cand_nxt = cand_r; cok_nxt = cok_r; fl_nxt = fl_r; kind_nxt = kind_r;
    acc_nxt = acc_r; stride_nxt = stride_r; vc_nxt = vc_r;
    seen_nxt = seen_r; err_nxt = err_r; load_total = 1'b0;
    pv_nxt = 1'b0; stop = 1'b0; ev = '0; tsum = '0; digit = '0; kidx = '0;

    if (ph_r == PH_PAY) begin
      if (seen_r < total_r) begin
        pv_nxt   = 1'b1;
        seen_nxt = seen_r + 1'b1;
      end
    end else if (ph_r == PH_PLY || ph_r == PH_HDR) begin
      if (in_tdata == " " || in_tdata == "\t") begin
        if (ciw_nxt != 5'd0) begin
          ev = eval_word(wi_nxt, ph_nxt == PH_PLY, fl_nxt, cand_nxt, ciw_nxt,
                         kind_nxt, cok_nxt);
          if (ev.err != E_NONE) begin
            stop = 1'b1; err_nxt = ev.err;
          end else begin
            kind_nxt = ev.kind;
            if (ev.inc_stride)
              stride_nxt = (stride_nxt > SMAX - STRIDE_BITS'(4)) ? SMAX
                                                                  : stride_nxt + STRIDE_BITS'(4);
            if (ev.load_vc) vc_nxt = acc_nxt;
            if (wi_nxt < 3'd7) wi_nxt = wi_nxt + 3'd1;
            ciw_nxt = '0; acc_nxt = '0; cand_nxt = '1; cok_nxt = 1'b1;
          end
        end else if (wi_nxt == 3'd0) begin
          fl_nxt = 1'b0;
        end
      end else if (in_tdata != "\n") begin
        for (int k = 0; k < NKW; k++) begin
          kidx = 5'(KW_LEN[k] - 5'd1 - ciw_r);
          if (cand_r[k] && ciw_r < KW_LEN[k] && in_tdata != KW_TEXT[k][8*kidx +: 8])
            cand_nxt[k] = 1'b0;
        end
        if (cok_r) begin
          if (in_tdata >= "0" && in_tdata <= "9") begin
            digit = 4'(in_tdata - "0");
            tsum = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                   + (COUNT_BITS+4)'(digit);
            if (tsum[COUNT_BITS+3:COUNT_BITS] != 4'd0) cok_nxt = 1'b0;
            else acc_nxt = tsum[COUNT_BITS-1:0];
          end else begin
            cok_nxt = 1'b0;
          end
        end
        if (ciw_r < 5'd31) ciw_nxt = ciw_r + 5'd1;
      end

      // line end, explicit or closed by the buffer end
      if (!stop && (in_tdata == "\n" || in_tlast)) begin
        if (ciw_nxt != 5'd0 || wi_nxt == 3'd0) begin
          ev = eval_word(wi_nxt, ph_nxt == PH_PLY, fl_nxt, cand_nxt, ciw_nxt,
                         kind_nxt, cok_nxt);
          if (ev.err != E_NONE) begin
            stop = 1'b1; err_nxt = ev.err;
          end else begin
            kind_nxt = ev.kind;
            if (ev.inc_stride)
              stride_nxt = (stride_nxt > SMAX - STRIDE_BITS'(4)) ? SMAX
                                                                  : stride_nxt + STRIDE_BITS'(4);
            if (ev.load_vc) vc_nxt = acc_nxt;
            if (wi_nxt < 3'd7) wi_nxt = wi_nxt + 3'd1;
            ciw_nxt = '0; acc_nxt = '0; cand_nxt = '1; cok_nxt = 1'b1;
          end
        end
        // missing words are checked as empty ones
        if (!stop && wi_nxt < words_needed(kind_nxt)) begin
          ev = eval_word(wi_nxt, ph_nxt == PH_PLY, fl_nxt, cand_nxt, ciw_nxt,
                         kind_nxt, cok_nxt);
          if (ev.err != E_NONE) begin
            stop = 1'b1; err_nxt = ev.err;
          end else begin
            kind_nxt = ev.kind;
            if (ev.inc_stride)
              stride_nxt = (stride_nxt > SMAX - STRIDE_BITS'(4)) ? SMAX
                                                                  : stride_nxt + STRIDE_BITS'(4);
            if (ev.load_vc) vc_nxt = acc_nxt;
          end
        end
        if (!stop) begin
          if (lc_r >= max_r) begin
            stop = 1'b1; err_nxt = E_LINES;
          end else begin
            lc_nxt = lc_r + 12'd1;
            if (kind_nxt == K_END) begin
              ph_nxt = PH_PAY; load_total = 1'b1; seen_nxt = '0;
            end else begin
              ph_nxt = PH_HDR;
            end
            wi_nxt = '0; kind_nxt = K_NONE; fl_nxt = 1'b1;
            ciw_nxt = '0; acc_nxt = '0; cand_nxt = '1; cok_nxt = 1'b1;
            if (in_tlast && ph_nxt != PH_PAY) begin
              stop = 1'b1; err_nxt = E_NO_END;
            end
          end
        end
      end
      if (stop) ph_nxt = PH_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_PLY; lc_r <= '0; max_r <= MAX_LINES_RST; wi_r <= '0;
      ciw_r <= '0; cand_r <= '1; cok_r <= 1'b1; fl_r <= 1'b1; kind_r <= K_NONE;
      acc_r <= '0; stride_r <= '0; vc_r <= '0; total_r <= '0; seen_r <= '0;
      err_r <= E_NONE; ovalid_r <= 1'b0; odata_r <= '0; ouser_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (in_fire) begin
        ph_r <= ph_nxt; lc_r <= lc_nxt; wi_r <= wi_nxt; ciw_r <= ciw_nxt;
        cand_r <= cand_nxt; cok_r <= cok_nxt; fl_r <= fl_nxt; kind_r <= kind_nxt;
        acc_r <= acc_nxt; stride_r <= stride_nxt; vc_r <= vc_nxt;
        seen_r <= seen_nxt; err_r <= err_nxt;
        // the header end line never touches count or stride, so the registers are final
        if (load_total) total_r <= prod;
        ouser_r  <= pv_nxt;
        odata_r  <= {6'd0, 12'(stride_nxt), 32'(vc_nxt), err_nxt,
                     (ph_nxt == PH_PAY) && (load_total ? (prod == '0)
                                                       : (seen_nxt >= total_r)),
                     ph_nxt == PH_PAY, pv_nxt ? in_tdata : 8'd0};
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != E_NONE) |=> (err_r == $past(err_r)))
    else $error("error code changed after stop");
  a_err_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != E_NONE) |-> (ph_r == PH_STOP))
    else $error("error without stop phase");
  a_pv_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ouser_r) |-> odata_r[8])
    else $error("payload byte before header done");
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_PAY) |-> (seen_r <= total_r))
    else $error("payload count overran total");

endmodule
